// ===== hw/rtl/i2p_pkg.sv =====
// shared constants, types and helpers for the infix to postfix converter
`default_nettype none

package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int SYM_W           = 8;

    localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_QUEST  = 8'h3F;
    localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE   = 8'h39;

    // bit positions inside the output tuser
    localparam int USER_DONE_BIT = 0;
    localparam int USER_OVF_BIT  = 1;
    localparam int USER_W        = 2;

    // one result leaving the sequencer
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done;
        logic             ovf;
    } emit_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic idle;
        logic pend_valid;
    } stat_t;

    // precedence as an ordered rank: other characters 0, then 1..3
    function automatic logic [1:0] prec_rank(input logic [SYM_W-1:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS || c == CH_QUEST)
            r = 2'd1;
        else if (c == CH_STAR || c == CH_SLASH)
            r = 2'd2;
        else if (c == CH_CARET)
            r = 2'd3;
        return r;
    endfunction

    function automatic logic is_digit(input logic [SYM_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2p_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module i2p_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/i2p_ctrl.sv =====
// stack sequencer: classifies symbols, pushes and pops the operator stack
`default_nettype none

module i2p_ctrl #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [i2p_pkg::SYM_W-1:0]      in_symbol,
    input  wire logic                           in_last,
    output logic                                in_ready,
    input  wire logic                           out_free,
    output i2p_pkg::emit_t                      emit,
    output i2p_pkg::stat_t                      stat,
    output logic                                ram_we,
    output logic [$clog2(STACK_DEPTH)-1:0]      ram_waddr,
    output logic [i2p_pkg::SYM_W-1:0]           ram_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0]      ram_raddr,
    input  wire logic [i2p_pkg::SYM_W-1:0]      ram_rdata
);

    import i2p_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_OPER  = 5'b00010,
        ST_PAREN = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_END   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [SYM_W-1:0] top_reg, top_next;
    logic [SYM_W-1:0] pend_reg, pend_next;
    logic             pendv_reg, pendv_next;
    logic             drop_reg, drop_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;

    logic             pop_emit, pop_drop, push_req, pop_go;
    logic [SYM_W-1:0] push_sym;
    logic [CW-1:0]    rd_sub;
    state_t           after_op;

    // state after the symbol itself is handled
    assign after_op = last_reg ? ST_FLUSH : ST_END;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        pend_next  = pend_reg;
        pendv_next = pendv_reg;
        drop_next  = drop_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        emit       = '0;
        ram_we     = 1'b0;
        ram_wdata  = sym_reg;
        ram_waddr  = cnt_reg[AW-1:0];
        pop_emit   = 1'b0;
        pop_drop   = 1'b0;
        push_req   = 1'b0;
        push_sym   = sym_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sym_next  = in_symbol;
                    last_next = in_last;
                    drop_next = 1'b0;
                    if (is_digit(in_symbol))
                    begin
                        pend_next  = in_symbol;
                        pendv_next = 1'b1;
                        state_next = in_last ? ST_FLUSH : ST_END;
                    end
                    else if (in_symbol == CH_LPAREN)
                    begin
                        push_req   = 1'b1;
                        push_sym   = in_symbol;
                        state_next = in_last ? ST_FLUSH : ST_END;
                    end
                    else if (in_symbol == CH_RPAREN)
                    begin
                        state_next = ST_PAREN;
                    end
                    else
                    begin
                        state_next = ST_OPER;
                    end
                end
            end
            ST_OPER:
            begin
                if (cnt_reg != '0 && prec_rank(top_reg) >= prec_rank(sym_reg))
                begin
                    pop_emit = 1'b1;
                end
                else
                begin
                    push_req   = 1'b1;
                    state_next = after_op;
                end
            end
            ST_PAREN:
            begin
                if (cnt_reg != '0 && top_reg != CH_LPAREN)
                begin
                    pop_emit = 1'b1;
                end
                else
                begin
                    // matching bracket is dropped, a stray ')' does nothing
                    pop_drop   = (cnt_reg != '0);
                    state_next = after_op;
                end
            end
            ST_FLUSH:
            begin
                if (cnt_reg != '0)
                    pop_emit = 1'b1;
                else
                    state_next = ST_END;
            end
            ST_END:
            begin
                if (!pendv_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.symbol = pend_reg;
                    emit.last   = 1'b1;
                    emit.done   = last_reg;
                    emit.ovf    = drop_reg;
                    pendv_next  = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // popped entry goes to the hold slot, the old hold entry moves out
        pop_go = pop_emit && (!pendv_reg || out_free);
        if (pop_go)
        begin
            if (pendv_reg)
            begin
                emit.valid  = 1'b1;
                emit.symbol = pend_reg;
                emit.ovf    = drop_reg;
            end
            pend_next  = top_reg;
            pendv_next = 1'b1;
        end
        if (pop_go || pop_drop)
        begin
            cnt_next = cnt_reg - CW'(1);
            top_next = ram_rdata;
        end
        if (push_req)
        begin
            if (cnt_reg < CW'(STACK_DEPTH))
            begin
                ram_we    = 1'b1;
                ram_wdata = push_sym;
                cnt_next  = cnt_reg + CW'(1);
                top_next  = push_sym;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
    end

    // keep the entry below the top on the read port at all times
    assign rd_sub    = cnt_next - CW'(2);
    assign ram_raddr = (cnt_next >= CW'(2)) ? rd_sub[AW-1:0] : '0;

    assign stat.idle       = (state_reg == ST_IDLE);
    assign stat.pend_valid = pendv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pendv_reg <= 1'b0;
            drop_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pendv_reg <= pendv_next;
            drop_reg  <= drop_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        pend_reg <= pend_next;
        sym_reg  <= sym_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/infix_to_postfix_converter_unit.sv =====
// top level of the infix to postfix converter with its output register
//
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready    | tdata: symbol; tlast: end_of_expr
// m_axis    | out | m_axis_tvalid/tready    | tdata: out_symbol; tlast: last_of_run;
//           |     |                         | tuser: expr_done, overflow
//
// a digit or '(' passes the accept state and a closing state that hands out
// the held result; an operator or ')' also passes a pop state that emits its
// pops and ends with the push, the discarded '(' or the check that finds none;
// an end mark adds a flush state that pops each entry until the stack is empty
// reset clears the stack count and sequencer; the stack ram is not cleared
// a stalled output holds the sequencer only when a result has to move out
`default_nettype none

module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [i2p_pkg::SYM_W-1:0]    s_axis_tdata,   // [7:0] symbol
    input  wire logic                         s_axis_tlast,   // end_of_expr
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [i2p_pkg::SYM_W-1:0]         m_axis_tdata,   // [7:0] out_symbol
    output logic                              m_axis_tlast,   // last_of_run
    output logic [i2p_pkg::USER_W-1:0]        m_axis_tuser    // [0] expr_done, [1] overflow
);

    import i2p_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    emit_t            emit;
    stat_t            stat;
    logic             out_free;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [SYM_W-1:0] ram_wdata;
    logic [SYM_W-1:0] ram_rdata;

    logic             out_valid_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic             out_last_reg;
    logic             out_done_reg;
    logic             out_ovf_reg;

    // the output register can take a new result this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    i2p_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_symbol (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_free  (out_free),
        .emit      (emit),
        .stat      (stat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // operator stack storage
    i2p_ram #(
        .WIDTH (SYM_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register: parts the sequencer from the downstream stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_sym_reg  <= emit.symbol;
            out_last_reg <= emit.last;
            out_done_reg <= emit.done;
            out_ovf_reg  <= emit.ovf;
        end
    end

    assign m_axis_tvalid                = out_valid_reg;
    assign m_axis_tdata                 = out_sym_reg;
    assign m_axis_tlast                 = out_last_reg;
    assign m_axis_tuser[USER_DONE_BIT]  = out_done_reg;
    assign m_axis_tuser[USER_OVF_BIT]   = out_ovf_reg;

`ifndef SYNTHESIS
    // the end of an expression always closes the run of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_DONE_BIT] |-> m_axis_tlast)
        else $error("expr_done without last_of_run");

    // a result never overwrites one still waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> out_free)
        else $error("result emitted into a full output register");

    // no held result may be left over when a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.idle |-> !stat.pend_valid)
        else $error("held result left behind at item boundary");
`endif

endmodule

`default_nettype wire
